// File: rtl/hsvrgb_pkg.sv
package hsvrgb_pkg;

    // Field widths fixed by the pixel format.
    localparam int HUE_W = 15;
    localparam int CH_W  = 8;

    // Full scale of an 8-bit channel.
    localparam int CH_FULL = 255;

    // Degrees per hue sector.
    localparam int SECT_DEG = 60;

    // Division by 15 of a 13-bit value: floor(((y + 1) * 4369) / 2^16).
    localparam int Y_W         = HUE_W - 2;
    localparam int RECIP15     = 4369;
    localparam int RECIP15_W   = 13;
    localparam int RECIP15_SH  = 16;
    localparam int KP_W        = Y_W + 1 + RECIP15_W;
    localparam int K_W         = 10;
    localparam int REMY_W      = 4;

    // Final scaling divides by 255 * 60 after the hue fraction bits are shifted out.
    // The quotient is exact for every dividend below 2^22 with this reciprocal.
    localparam int DIV_BASE    = CH_FULL * SECT_DEG;
    localparam int M_W         = 22;
    localparam int DIV_RECIP   = 4491470;
    localparam int DIV_RECIP_W = 23;
    localparam int DIV_SH      = 36;
    localparam int DPROD_W     = M_W + DIV_RECIP_W;

    // Hue sector, red through magenta.
    typedef enum logic [2:0] {
        SEC_RED     = 3'd0,
        SEC_YELLOW  = 3'd1,
        SEC_GREEN   = 3'd2,
        SEC_CYAN    = 3'd3,
        SEC_BLUE    = 3'd4,
        SEC_MAGENTA = 3'd5
    } t_sector;

endpackage

// File: rtl/hsv_to_rgb_converter.sv
// Channel  Direction  Handshake            Word
// -------  ---------  -------------------  ---------------------------------------
// input    in         i_valid / o_ready    i_hue, i_saturation, i_brightness
// output   out        o_valid / i_ready    o_red, o_green, o_blue
//
// One word is accepted every clock cycle while the output side is not stalled;
// each result passes through the six register stages of the datapath.
// Every stage holds its own valid bit and advances whenever the stage after it
// is empty or advancing, so bubbles are squeezed out and a stall loses nothing.
// The synchronous active-low reset clears only the valid bits.
module hsv_to_rgb_converter
    import hsvrgb_pkg::*;
#(
    parameter int HUE_FRAC_BITS = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [HUE_W-1:0]    i_hue,
    input  logic [CH_W-1:0]     i_saturation,
    input  logic [CH_W-1:0]     i_brightness,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [CH_W-1:0]     o_red,
    output logic [CH_W-1:0]     o_green,
    output logic [CH_W-1:0]     o_blue
);

    // Width of one hue sector in hue units, and the derived widths.
    localparam int SECT_D  = SECT_DEG << HUE_FRAC_BITS;
    localparam int REM_W   = $clog2(SECT_D);
    localparam int A_W     = $clog2(CH_FULL * SECT_D + 1);
    localparam int SR_W    = CH_W + REM_W;
    localparam int N_W     = CH_W + A_W;
    localparam int FULL_A  = CH_FULL * SECT_D;
    localparam int HALF    = FULL_A / 2;
    localparam int STAGES  = 6;

    // Pipeline control. A stage may load when it is empty or when the stage
    // after it loads in the same cycle.
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] en;

    always_comb begin
        en[STAGES-1] = !r_vld[STAGES-1] || i_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage A: input capture.
    logic [HUE_W-1:0] r_a_hue;
    logic [CH_W-1:0]  r_a_sat;
    logic [CH_W-1:0]  r_a_vbr;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_a_hue <= i_hue;
            r_a_sat <= i_saturation;
            r_a_vbr <= i_brightness;
        end
    end

    // The sector index is hue / (60 << F) = (hue >> (F + 2)) / 15. The quotient
    // by 15 comes from a reciprocal multiply that is exact over 13 bits.
    logic [Y_W-1:0]  a_y;
    logic [KP_W-1:0] a_kprod;

    assign a_y     = Y_W'(r_a_hue >> (HUE_FRAC_BITS + 2));
    assign a_kprod = (KP_W'(a_y) + KP_W'(1)) * KP_W'(RECIP15);

    // Stage B: coarse quotient held, remainder and sector formed next.
    logic [HUE_W-1:0] r_b_hue;
    logic [K_W-1:0]   r_b_k;
    logic [CH_W-1:0]  r_b_sat;
    logic [CH_W-1:0]  r_b_vbr;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_b_hue <= r_a_hue;
            r_b_k   <= a_kprod[RECIP15_SH +: K_W];
            r_b_sat <= r_a_sat;
            r_b_vbr <= r_a_vbr;
        end
    end

    logic [Y_W-1:0]    b_y;
    logic [Y_W-1:0]    b_ydiff;
    logic [REM_W-1:0]  b_rem;
    t_sector           b_sector;

    assign b_y     = Y_W'(r_b_hue >> (HUE_FRAC_BITS + 2));
    assign b_ydiff = b_y - Y_W'(r_b_k) * Y_W'(15);
    assign b_rem   = {b_ydiff[REMY_W-1:0], r_b_hue[HUE_FRAC_BITS+1:0]};

    // Hues at or past 360 degrees fold into the magenta sector.
    always_comb begin
        if (r_b_k >= K_W'(SEC_MAGENTA)) begin
            b_sector = SEC_MAGENTA;
        end else begin
            b_sector = t_sector'(r_b_k[2:0]);
        end
    end

    // Stage C: remainder and sector held; the three scale numerators follow.
    logic [REM_W-1:0] r_c_rem;
    t_sector          r_c_sector;
    logic [CH_W-1:0]  r_c_sat;
    logic [CH_W-1:0]  r_c_vbr;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_c_rem    <= b_rem;
            r_c_sector <= b_sector;
            r_c_sat    <= r_b_sat;
            r_c_vbr    <= r_b_vbr;
        end
    end

    // With sr = s * rem, the numerators are
    //   p: (255 - s) * D,   q: 255 * D - sr,   t: (255 - s) * D + sr.
    // At zero saturation all three equal 255 * D, so every channel is v.
    logic [SR_W-1:0] c_sr;
    logic [A_W-1:0]  c_ap;
    logic [A_W-1:0]  c_aq;
    logic [A_W-1:0]  c_at;

    assign c_sr = SR_W'(r_c_sat) * SR_W'(r_c_rem);
    assign c_ap = A_W'(CH_W'(CH_FULL) - r_c_sat) * A_W'(SECT_D);
    assign c_aq = A_W'(FULL_A) - A_W'(c_sr);
    assign c_at = c_ap + A_W'(c_sr);

    // Stage D: numerators held; each is scaled by the value channel.
    logic [A_W-1:0]  r_d_ap;
    logic [A_W-1:0]  r_d_aq;
    logic [A_W-1:0]  r_d_at;
    t_sector         r_d_sector;
    logic [CH_W-1:0] r_d_vbr;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_d_ap     <= c_ap;
            r_d_aq     <= c_aq;
            r_d_at     <= c_at;
            r_d_sector <= r_c_sector;
            r_d_vbr    <= r_c_vbr;
        end
    end

    // Adding half the divisor gives round to nearest with ties upward.
    logic [N_W-1:0] d_np;
    logic [N_W-1:0] d_nq;
    logic [N_W-1:0] d_nt;

    assign d_np = N_W'(r_d_vbr) * N_W'(r_d_ap) + N_W'(HALF);
    assign d_nq = N_W'(r_d_vbr) * N_W'(r_d_aq) + N_W'(HALF);
    assign d_nt = N_W'(r_d_vbr) * N_W'(r_d_at) + N_W'(HALF);

    // Stage E: products held; division by 255 * D follows. The 2^HUE_FRAC_BITS
    // factor of D is a shift, the rest a reciprocal multiply by 1 / 15300.
    logic [N_W-1:0]  r_e_np;
    logic [N_W-1:0]  r_e_nq;
    logic [N_W-1:0]  r_e_nt;
    t_sector         r_e_sector;
    logic [CH_W-1:0] r_e_vbr;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_e_np     <= d_np;
            r_e_nq     <= d_nq;
            r_e_nt     <= d_nt;
            r_e_sector <= r_d_sector;
            r_e_vbr    <= r_d_vbr;
        end
    end

    logic [DPROD_W-1:0] e_dp;
    logic [DPROD_W-1:0] e_dq;
    logic [DPROD_W-1:0] e_dt;
    logic [CH_W-1:0]    e_p;
    logic [CH_W-1:0]    e_q;
    logic [CH_W-1:0]    e_t;

    assign e_dp = DPROD_W'(r_e_np[HUE_FRAC_BITS +: M_W]) * DPROD_W'(DIV_RECIP);
    assign e_dq = DPROD_W'(r_e_nq[HUE_FRAC_BITS +: M_W]) * DPROD_W'(DIV_RECIP);
    assign e_dt = DPROD_W'(r_e_nt[HUE_FRAC_BITS +: M_W]) * DPROD_W'(DIV_RECIP);
    assign e_p  = e_dp[DIV_SH +: CH_W];
    assign e_q  = e_dq[DIV_SH +: CH_W];
    assign e_t  = e_dt[DIV_SH +: CH_W];

    // Route the terms to the channels by sector.
    logic [CH_W-1:0] e_red;
    logic [CH_W-1:0] e_green;
    logic [CH_W-1:0] e_blue;

    always_comb begin
        unique case (r_e_sector)
            SEC_RED: begin
                e_red = r_e_vbr; e_green = e_t;     e_blue = e_p;
            end
            SEC_YELLOW: begin
                e_red = e_q;     e_green = r_e_vbr; e_blue = e_p;
            end
            SEC_GREEN: begin
                e_red = e_p;     e_green = r_e_vbr; e_blue = e_t;
            end
            SEC_CYAN: begin
                e_red = e_p;     e_green = e_q;     e_blue = r_e_vbr;
            end
            SEC_BLUE: begin
                e_red = e_t;     e_green = e_p;     e_blue = r_e_vbr;
            end
            default: begin
                e_red = r_e_vbr; e_green = e_p;     e_blue = e_q;
            end
        endcase
    end

    // Output register.
    logic [CH_W-1:0] r_red;
    logic [CH_W-1:0] r_green;
    logic [CH_W-1:0] r_blue;

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_red   <= e_red;
            r_green <= e_green;
            r_blue  <= e_blue;
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

// File: tb/hsv_pixel_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the converter, predicts each pixel from its input
// word and compares the output words in order.
module hsv_pixel_checker
    import hsvrgb_pkg::*;
#(
    parameter int HUE_FRAC_BITS = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             o_ready,
    input  logic [HUE_W-1:0] i_hue,
    input  logic [CH_W-1:0]  i_saturation,
    input  logic [CH_W-1:0]  i_brightness,
    input  logic             o_valid,
    input  logic             i_ready,
    input  logic [CH_W-1:0]  o_red,
    input  logic [CH_W-1:0]  o_green,
    input  logic [CH_W-1:0]  o_blue,
    output int               o_fail_count,
    output int               o_pending
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    typedef struct {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  sat;
        logic [CH_W-1:0]  val;
        t_rgb             rgb;
    } t_pixel;

    t_pixel expected_pixels[$];
    int     mismatches = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // brightness * num / den, rounded to nearest with ties upward.
    function automatic longint unsigned rounded_term(input longint unsigned v,
                                                     input longint unsigned num,
                                                     input longint unsigned den);
        return (v * num + den / 2) / den;
    endfunction

    function automatic t_rgb hsv_to_rgb_predict(input logic [HUE_W-1:0] hue,
                                                input logic [CH_W-1:0]  sat,
                                                input logic [CH_W-1:0]  val);
        longint unsigned span;
        longint unsigned full;
        longint unsigned h;
        longint unsigned s;
        longint unsigned v;
        longint unsigned sector_num;
        longint unsigned rem;
        longint unsigned p;
        longint unsigned q;
        longint unsigned t;
        t_sector         sector;
        t_rgb            px;
        span = longint'(SECT_DEG) << HUE_FRAC_BITS;
        full = longint'(CH_FULL) * span;
        h    = hue;
        s    = sat;
        v    = val;
        if (s == 0) begin
            px.red   = val;
            px.green = val;
            px.blue  = val;
            return px;
        end
        sector_num = h / span;
        rem        = h % span;
        // A hue at or past 360 degrees is routed like the magenta sector.
        sector = (sector_num > SEC_MAGENTA) ? SEC_MAGENTA : t_sector'(sector_num[2:0]);
        p = rounded_term(v, (longint'(CH_FULL) - s) * span, full);
        q = rounded_term(v, full - s * rem, full);
        t = rounded_term(v, full - s * (span - rem), full);
        case (sector)
            SEC_RED: begin
                px.red = val;        px.green = t[CH_W-1:0]; px.blue = p[CH_W-1:0];
            end
            SEC_YELLOW: begin
                px.red = q[CH_W-1:0]; px.green = val;        px.blue = p[CH_W-1:0];
            end
            SEC_GREEN: begin
                px.red = p[CH_W-1:0]; px.green = val;        px.blue = t[CH_W-1:0];
            end
            SEC_CYAN: begin
                px.red = p[CH_W-1:0]; px.green = q[CH_W-1:0]; px.blue = val;
            end
            SEC_BLUE: begin
                px.red = t[CH_W-1:0]; px.green = p[CH_W-1:0]; px.blue = val;
            end
            default: begin
                px.red = val;        px.green = p[CH_W-1:0]; px.blue = q[CH_W-1:0];
            end
        endcase
        return px;
    endfunction

    always @(posedge i_clk) begin : track_words
        t_pixel want;
        t_rgb   got;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                want.hue = i_hue;
                want.sat = i_saturation;
                want.val = i_brightness;
                want.rgb = hsv_to_rgb_predict(i_hue, i_saturation, i_brightness);
                expected_pixels.push_back(want);
            end
            if (o_valid && i_ready) begin
                got.red   = o_red;
                got.green = o_green;
                got.blue  = o_blue;
                if (expected_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected output word rgb=(%0d,%0d,%0d)",
                                 $realtime, got.red, got.green, got.blue);
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.red !== want.rgb.red || got.green !== want.rgb.green ||
                        got.blue !== want.rgb.blue) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display(
                                "%0t: hsv=(%0d,%0d,%0d) expected=(%0d,%0d,%0d) got=(%0d,%0d,%0d)",
                                $realtime, want.hue, want.sat, want.val,
                                want.rgb.red, want.rgb.green, want.rgb.blue,
                                got.red, got.green, got.blue);
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_pixels.size();
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

// Top of the converter testbench. It makes the clock and reset, drives input
// words with random gaps, stalls the output side at random, and gives the
// verdict. Prediction and comparison live in the checker instance.
module tb;
    import hsvrgb_pkg::*;

    localparam int HUE_FRAC_BITS = 6;

    // Hue units per 60-degree sector, the last legal hue below 360 degrees,
    // and the largest value the hue port can carry.
    localparam int SPAN     = SECT_DEG << HUE_FRAC_BITS;
    localparam int HUE_LAST = 6 * SPAN - 1;
    localparam int HUE_TOP  = (1 << HUE_W) - 1;

    localparam int RANDOM_WORDS = 500;
    // The last words of the run go through with no idling on either side.
    localparam int CALM_WORDS   = 60;
    // Six pipeline stages; a few extra cycles catch any stray output word.
    localparam int DRAIN_CYCLES = 16;
    // Slowest correct run: the longest sender gap plus the longest receiver stall
    // plus the pipeline depth between accepted words. Taken many times over.
    localparam int IDLE_LIMIT   = 2000;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    logic [HUE_W-1:0] i_hue;
    logic [CH_W-1:0]  i_saturation;
    logic [CH_W-1:0]  i_brightness;
    logic             o_valid;
    logic             i_ready;
    logic [CH_W-1:0]  o_red;
    logic [CH_W-1:0]  o_green;
    logic [CH_W-1:0]  o_blue;

    int   fail_count;
    int   pending;
    logic calm_tail;

    hsv_to_rgb_converter #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    hsv_pixel_checker #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Offers one input word. It is called at a falling edge, may first hold
    // valid low for a short burst, then keeps the word steady until the
    // rising edge at which it is taken, and returns at the next falling edge.
    task automatic send_pixel(input logic [HUE_W-1:0] hue,
                              input logic [CH_W-1:0]  sat,
                              input logic [CH_W-1:0]  val);
        int gap;
        if (!calm_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_hue        <= hue;
        i_saturation <= sat;
        i_brightness <= val;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Picks a channel value that lands on zero or full scale now and then.
    function automatic logic [CH_W-1:0] pick_level();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return CH_W'(CH_FULL);
        return CH_W'($urandom_range(0, CH_FULL));
    endfunction

    // The receiver drops ready at random, and holds it
    // high for good once the calm tail of the run begins.
    initial begin : output_stalls
        int stall_left;
        stall_left = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
            end else if (!calm_tail && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 4) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Ends the run if neither channel moves a word for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("** hsv_to_rgb_converter: FAILED **");
        $finish;
    end

    initial begin : stimulus
        int               roll;
        logic [HUE_W-1:0] hue;
        calm_tail    = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_hue        = '0;
        i_saturation = '0;
        i_brightness = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Zero saturation gives a gray pixel at the value, whatever the hue.
        send_pixel('0, '0, '0);
        send_pixel('0, '0, CH_W'(CH_FULL));
        send_pixel(HUE_W'(HUE_LAST), '0, 8'd128);
        // Full saturation and value at the start of each sector, so every
        // sector's routing of p, q and t is seen with clean edge values.
        for (int k = 0; k < 6; k++)
            send_pixel(HUE_W'(k * SPAN), CH_W'(CH_FULL), CH_W'(CH_FULL));
        // Last hue unit of a sector and the last hue below 360 degrees.
        send_pixel(HUE_W'(SPAN - 1), CH_W'(CH_FULL), CH_W'(CH_FULL));
        send_pixel(HUE_W'(HUE_LAST), CH_W'(CH_FULL), CH_W'(CH_FULL));
        // Mid-sector fraction with ordinary levels.
        send_pixel(HUE_W'(SPAN / 2), 8'd128, 8'd200);
        // Hues at or past 360 degrees fall into the magenta routing.
        send_pixel(HUE_W'(HUE_LAST + 1), 8'd200, CH_W'(CH_FULL));
        send_pixel(HUE_W'(HUE_TOP), CH_W'(CH_FULL), CH_W'(CH_FULL));
        // Smallest nonzero saturation, black, and a dim odd pixel.
        send_pixel(15'd16384, 8'd1, CH_W'(CH_FULL));
        send_pixel(15'd5000, CH_W'(CH_FULL), '0);
        send_pixel(15'd12345, 8'd77, 8'd1);

        // Random pixels: mostly legal hues, some past 360 degrees, and some
        // right on a sector boundary or one unit below it.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS - CALM_WORDS) calm_tail = 1'b1;
            roll = $urandom_range(0, 19);
            if (roll < 2)
                hue = HUE_W'($urandom_range(HUE_LAST + 1, HUE_TOP));
            else if (roll == 2)
                hue = HUE_W'($urandom_range(0, 5) * SPAN);
            else if (roll == 3)
                hue = HUE_W'($urandom_range(1, 6) * SPAN - 1);
            else
                hue = HUE_W'($urandom_range(0, HUE_LAST));
            send_pixel(hue, pick_level(), pick_level());
        end
        i_valid <= 1'b0;

        // Let every predicted word come out, then watch a little longer for
        // anything the converter should not have produced.
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("** hsv_to_rgb_converter: PASSED **");
        else
            $display("** hsv_to_rgb_converter: FAILED **");
        $finish;
    end

endmodule
